FILE: hw/rtl/ahgs_pkg.sv
// Shared types, constants and kernel table functions for the angular histogram smoother.
package ahgs_pkg;

  localparam int SPREAD_DEGREES_DEF   = 11;
  localparam int COUNT_BITS_DEF       = 24;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  localparam int NUM_ANGLES = 180;
  localparam int NUM_BINS   = 360;
  localparam int HALF_TURN  = 180;
  localparam int ACC_W      = 48;
  localparam int TOTAL_W    = 57;
  localparam int DENS_W     = 25;
  localparam int DENS_FRAC  = 24;
  localparam int ANG_W      = 8;
  localparam int BIN_W      = 9;
  localparam int COUNT_IN_W = 24;
  localparam int DIV_STEPS  = DENS_FRAC + 1;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_COMPUTE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]            command;
    logic [ANG_W-1:0]      angle;
    logic [COUNT_IN_W-1:0] count;
    logic [BIN_W-1:0]      bin;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [BIN_W-1:0]  bin_index;
    logic [DENS_W-1:0] density;
    logic              no_data;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIN,
    ST_MIN_DRAIN,
    ST_GATHER,
    ST_DRAIN,
    ST_STORE,
    ST_RD_ADDR,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take;
    logic min_issue;
    logic gather_issue;
    logic acc_store;
    logic div_load;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ang_last;
    logic j_last;
    logic bin_last;
    logic pipe_empty;
    logic read_trivial;
    logic div_done;
    logic out_full;
  } dp_stat_t;

  // Shift-subtract division, evaluated only while building the kernel table.
  function automatic logic [127:0] div_u128(input logic [127:0] num, input logic [127:0] den);
    logic [127:0] q;
    logic [127:0] r;
    q = '0;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      r = {r[126:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[125:62];
  endfunction

  // Kernel entry for distance d: exp(-d^2 * 2.7730125 / s^2) rounded to wfb fraction bits.
  function automatic logic [63:0] gauss_weight(input int d, input int s, input int wfb);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    logic [63:0]  y;
    logic [63:0]  t;
    logic [63:0]  m;
    num = 128'(d * d) * 128'd27730125;
    den = 128'(s * s) * 128'd10000000;
    q   = div_u128(num << 50, den);
    y   = q[63:0];
    t   = 64'd1 << 62;
    for (int k = 6; k >= 1; k--) begin
      m = mul_q62(y, t);
      q = div_u128({64'b0, m}, 128'(k));
      t = (64'd1 << 62) - q[63:0];
    end
    for (int h = 0; h < 12; h++) begin
      t = mul_q62(t, t);
    end
    return (t + (64'd1 << (61 - wfb))) >> (62 - wfb);
  endfunction

endpackage

FILE: hw/rtl/ahgs_in_if.sv
// Input channel interface: valid, ready and one command item.
interface ahgs_in_if;
  import ahgs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ahgs_out_if.sv
// Output channel interface: valid, ready and one result item.
interface ahgs_out_if;
  import ahgs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/angular_histogram_gauss_smooth.sv
// Top level of the circular Gaussian smoother for an angular histogram.
//
//   Channel  Dir  Carries
//   req      in   command, angle, count, bin
//   rsp      out  result_kind, bin_index, density, no_data
//
// A load or a clear gives no result. A read, when the map holds data and
// the bin is in range, makes one map memory read, then runs a one-bit-per-
// cycle divider that forms the 25-bit share. A compute makes one pass over
// the 180 stored counts for the baseline, then for each of the 360 bins a
// pipelined walk over all 360 kernel centers, one multiply per cycle.
// Reset (synchronous, active high) empties the count store and zeroes the
// map total. A stalled result stays in the output register; load and clear
// items are still taken meanwhile whenever the controller is idle.
module angular_histogram_gauss_smooth #(
  parameter int SPREAD_DEGREES   = ahgs_pkg::SPREAD_DEGREES_DEF,
  parameter int COUNT_BITS       = ahgs_pkg::COUNT_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = ahgs_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  ahgs_in_if.sink  req,
  ahgs_out_if.source rsp
);
  import ahgs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  // The controller sequences the phases; it only sees the command code.
  ahgs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.data.command),
    .in_ready   (in_ready),
    .out_ready  (rsp.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath owns every store, the pipeline and the output register.
  ahgs_dp #(
    .SPREAD_DEGREES   (SPREAD_DEGREES),
    .COUNT_BITS       (COUNT_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (req.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (rsp.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;
endmodule

FILE: hw/rtl/ahgs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ahgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/ahgs_ctrl.sv
// Sequencer for load, clear, compute and read commands.
module ahgs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_command,
  output logic                 in_ready,
  input  logic                 out_ready,
  input  ahgs_pkg::dp_stat_t   stat,
  output ahgs_pkg::ctrl_cmd_t  cmd
);
  import ahgs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_COMPUTE) begin
            state_next = ST_MIN;
          end else if (in_command == CMD_READ) begin
            state_next = ST_RD_ADDR;
          end
        end
      end
      ST_MIN:       if (stat.ang_last) state_next = ST_MIN_DRAIN;
      ST_MIN_DRAIN: if (stat.pipe_empty) state_next = ST_GATHER;
      ST_GATHER:    if (stat.j_last) state_next = ST_DRAIN;
      ST_DRAIN:     if (stat.pipe_empty) state_next = ST_STORE;
      ST_STORE:     state_next = stat.bin_last ? ST_FINISH : ST_GATHER;
      ST_RD_ADDR:   state_next = stat.read_trivial ? ST_FINISH : ST_DIV_LOAD;
      ST_DIV_LOAD:  state_next = ST_DIV;
      ST_DIV:       if (stat.div_done) state_next = ST_FINISH;
      ST_FINISH:    if (!stat.out_full || out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state == ST_IDLE);
    cmd.take         = (state == ST_IDLE) && in_valid;
    cmd.min_issue    = (state == ST_MIN);
    cmd.gather_issue = (state == ST_GATHER);
    cmd.acc_store    = (state == ST_STORE);
    cmd.div_load     = (state == ST_DIV_LOAD);
    cmd.div_step     = (state == ST_DIV) && !stat.div_done;
    cmd.emit         = (state == ST_FINISH) && (!stat.out_full || out_ready);
  end
endmodule

FILE: hw/rtl/ahgs_dp.sv
// Datapath: count store, baseline search, kernel gather pipeline, bin map and divider.
module ahgs_dp #(
  parameter int SPREAD_DEGREES   = ahgs_pkg::SPREAD_DEGREES_DEF,
  parameter int COUNT_BITS       = ahgs_pkg::COUNT_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = ahgs_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ahgs_pkg::in_item_t   in_item,
  input  ahgs_pkg::ctrl_cmd_t  cmd,
  output ahgs_pkg::dp_stat_t   stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output ahgs_pkg::out_item_t  out_item
);
  import ahgs_pkg::*;

  localparam int WW       = WEIGHT_FRAC_BITS + 1;
  localparam int PW       = COUNT_BITS + WW;
  localparam int SW       = ((PW > ACC_W) ? PW : ACC_W) + 1;
  localparam int REACH    = 3 * SPREAD_DEGREES;
  localparam int ROM_LEN  = REACH + 1;
  localparam int RI       = $clog2(ROM_LEN);
  localparam int AW       = $clog2(NUM_ANGLES);
  localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [DENS_W-1:0]  DENS_ONE  = DENS_W'(1) << DENS_FRAC;

  // Kernel table, one entry per distance in degrees.
  logic [WW-1:0] rom [ROM_LEN];
  for (genvar g = 0; g < ROM_LEN; g++) begin : g_rom
    localparam logic [63:0] WV = gauss_weight(g, SPREAD_DEGREES, WEIGHT_FRAC_BITS);
    assign rom[g] = WV[WW-1:0];
  end

  logic [NUM_ANGLES-1:0] flags;
  logic [1:0]            item_cmd;
  logic [BIN_W-1:0]      rd_bin;
  logic [ANG_W-1:0]      ang;
  logic [BIN_W-1:0]      j;
  logic [BIN_W-1:0]      bin_cnt;
  logic [COUNT_BITS-1:0] base;
  logic                  found;
  logic                  s1_min;
  logic                  s1_g;
  logic                  s1_flag;
  logic [BIN_W-1:0]      s1_center;
  logic                  s2_v;
  logic [COUNT_BITS-1:0] s2_delta;
  logic [WW-1:0]         s2_w;
  logic                  s3_v;
  logic [PW-1:0]         s3_prod;
  logic [ACC_W-1:0]      acc;
  logic [TOTAL_W-1:0]    total;
  logic [TOTAL_W:0]      rem;
  logic [DENS_W-1:0]     quo;
  logic [4:0]            dcnt;

  logic [COUNT_BITS-1:0] load_cnt;
  logic                  load_ok;
  logic [ANG_W-1:0]      load_addr;
  logic [ANG_W-1:0]      j_fold;
  logic [ANG_W-1:0]      cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [BIN_W-1:0]      acc_raddr;
  logic [ACC_W-1:0]      acc_rdata;
  logic [BIN_W-1:0]      diff;
  logic [BIN_W-1:0]      cdist;
  logic [SW-1:0]         acc_sum;
  logic [TOTAL_W:0]      tot_sum;
  logic [TOTAL_W:0]      trial;
  logic                  ge;
  logic [DENS_W-1:0]     dens;
  logic                  is_read;

  assign load_cnt  = COUNT_BITS'(in_item.count);
  assign load_ok   = (in_item.angle >= ANG_W'(1)) && (in_item.angle <= ANG_W'(NUM_ANGLES))
                     && (load_cnt != '0);
  assign load_addr = in_item.angle - ANG_W'(1);
  assign j_fold    = (j >= BIN_W'(HALF_TURN)) ? ANG_W'(j - BIN_W'(HALF_TURN)) : ANG_W'(j);
  assign cnt_raddr = cmd.gather_issue ? j_fold : ang;
  assign acc_raddr = (rd_bin < BIN_W'(NUM_BINS)) ? rd_bin : '0;

  ahgs_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_ANGLES)) u_counts (
    .clk   (clk),
    .we    (cmd.take && (in_item.command == CMD_LOAD) && load_ok),
    .waddr (load_addr[AW-1:0]),
    .wdata (load_cnt),
    .raddr (cnt_raddr[AW-1:0]),
    .rdata (cnt_rdata)
  );

  ahgs_ram #(.WIDTH(ACC_W), .DEPTH(NUM_BINS)) u_map (
    .clk   (clk),
    .we    (cmd.acc_store),
    .waddr (bin_cnt),
    .wdata (acc),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  // Circular distance between the bin under construction and the current center.
  assign diff    = (bin_cnt > s1_center) ? bin_cnt - s1_center : s1_center - bin_cnt;
  assign cdist   = (diff > BIN_W'(HALF_TURN)) ? BIN_W'(NUM_BINS) - diff : diff;
  assign acc_sum = SW'(acc) + SW'(s3_prod);
  assign tot_sum = {1'b0, total} + (TOTAL_W + 1)'(acc);
  assign trial   = (dcnt == 5'd0) ? rem : {rem[TOTAL_W-1:0], 1'b0};
  assign ge      = trial >= {1'b0, total};
  assign is_read = (item_cmd == CMD_READ);

  always_comb begin
    dens = '0;
    if (is_read && !stat.read_trivial) begin
      dens = (quo > DENS_ONE) ? DENS_ONE : quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
      s1_min    <= 1'b0;
      s1_g      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      ang       <= '0;
      j         <= '0;
      bin_cnt   <= '0;
      dcnt      <= '0;
      found     <= 1'b0;
    end else begin
      s1_min <= cmd.min_issue;
      s1_g   <= cmd.gather_issue;
      s2_v   <= s1_g;
      s3_v   <= s2_v;

      if (cmd.take) begin
        ang     <= '0;
        j       <= '0;
        bin_cnt <= '0;
        if (in_item.command == CMD_LOAD && load_ok) begin
          flags[load_addr[AW-1:0]] <= 1'b1;
        end
        if (in_item.command == CMD_CLEAR) begin
          flags <= '0;
        end
        if (in_item.command == CMD_COMPUTE) begin
          total <= '0;
          found <= 1'b0;
        end
      end

      if (cmd.min_issue) begin
        ang <= ang + ANG_W'(1);
      end
      if (s1_min && s1_flag && (!found || cnt_rdata < base)) begin
        found <= 1'b1;
      end

      if (cmd.gather_issue) begin
        j <= (j == BIN_W'(NUM_BINS - 1)) ? '0 : j + BIN_W'(1);
      end

      if (cmd.acc_store) begin
        bin_cnt <= bin_cnt + BIN_W'(1);
        total   <= tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
      end

      if (cmd.div_load) begin
        dcnt <= '0;
      end else if (cmd.div_step) begin
        dcnt <= dcnt + 5'd1;
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_cmd <= in_item.command;
      rd_bin   <= in_item.bin;
      if (in_item.command == CMD_COMPUTE) begin
        base <= '0;
        acc  <= '0;
      end
    end
    if (s1_min && s1_flag && (!found || cnt_rdata < base)) begin
      base <= cnt_rdata;
    end
    s1_flag   <= flags[cnt_raddr[AW-1:0]];
    s1_center <= (j == BIN_W'(NUM_BINS - 1)) ? '0 : j + BIN_W'(1);
    s2_delta  <= s1_flag ? cnt_rdata - base : '0;
    s2_w      <= (cdist <= BIN_W'(REACH)) ? rom[cdist[RI-1:0]] : '0;
    s3_prod   <= PW'(s2_delta) * PW'(s2_w);
    if (s3_v) begin
      acc <= (acc_sum > SW'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
    end
    if (cmd.acc_store) begin
      acc <= '0;
    end
    if (cmd.div_load) begin
      rem <= (TOTAL_W + 1)'(acc_rdata);
      quo <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? trial - {1'b0, total} : trial;
      quo <= {quo[DENS_W-2:0], ge};
    end
    if (cmd.emit) begin
      out_item.result_kind <= is_read;
      out_item.bin_index   <= is_read ? rd_bin : '0;
      out_item.density     <= dens;
      out_item.no_data     <= (total == '0);
    end
  end

  always_comb begin
    stat.ang_last     = (ang == ANG_W'(NUM_ANGLES - 1));
    stat.j_last       = (j == BIN_W'(NUM_BINS - 1));
    stat.bin_last     = (bin_cnt == BIN_W'(NUM_BINS - 1));
    stat.pipe_empty   = !s1_min && !s1_g && !s2_v && !s3_v;
    stat.read_trivial = (total == '0) || (rd_bin >= BIN_W'(NUM_BINS));
    stat.div_done     = (dcnt == 5'(DIV_STEPS));
    stat.out_full     = out_valid;
  end
endmodule

FILE: bench/tb_angular_histogram_gauss_smooth.sv
// Testbench for the angular histogram Gaussian smoother: directed and random items, scoreboard.
`timescale 1ns / 100ps

module tb_angular_histogram_gauss_smooth;
  import ahgs_pkg::*;

  // Kernel reach and the limit of the stall watchdog. A compute accepts no
  // items while it runs, so the limit leaves room for a whole compute.
  localparam int SPREAD     = SPREAD_DEGREES_DEF;
  localparam int REACH      = 3 * SPREAD;
  localparam int N_RANDOM   = 1930;
  localparam int QUIET_TAIL = 150;
  localparam int WATCH_MAX  = 600000;
  localparam int HOLD_LEN   = 400;

  localparam logic [63:0] ACC_SAT   = (64'd1 << ACC_W) - 1;
  localparam logic [63:0] TOTAL_SAT = (64'd1 << TOTAL_W) - 1;
  localparam logic [63:0] ONE_Q62   = 64'd1 << 62;

  // The scoreboard keeps its own copy of the block's state, works out the
  // result of every accepted item and matches the results in order.
  class smooth_scoreboard;
    logic [COUNT_IN_W-1:0] counts[NUM_ANGLES];
    bit                    present[NUM_ANGLES];
    logic [63:0]           bin_acc[NUM_BINS];
    logic [63:0]           map_total;
    logic [63:0]           kernel[REACH+1];
    out_item_t             pending[$];
    int                    errors;

    function new();
      for (int a = 0; a < NUM_ANGLES; a++) begin
        counts[a]  = '0;
        present[a] = 0;
      end
      for (int b = 0; b < NUM_BINS; b++) bin_acc[b] = '0;
      map_total = '0;
      errors    = 0;
      for (int d = 0; d <= REACH; d++) kernel[d] = kernel_weight(d);
    endfunction

    // Q2.62 product, truncated.
    function logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
    endfunction

    // exp(-x) with x = d^2 * 2.7730125 / s^2: Horner series of x/4096,
    // then twelve squarings, then rounding half up to the weight width.
    function logic [63:0] kernel_weight(int d);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      logic [63:0]  y;
      logic [63:0]  t;
      num = (128'(d * d) * 128'd27730125) << 50;
      den = 128'(SPREAD * SPREAD) * 128'd10000000;
      quo = num / den;
      y   = quo[63:0];
      t   = ONE_Q62;
      for (int k = 6; k >= 1; k--) t = ONE_Q62 - q62_mul(y, t) / 64'(k);
      for (int h = 0; h < 12; h++) t = q62_mul(t, t);
      return (t + (64'd1 << (61 - WEIGHT_FRAC_BITS_DEF))) >> (62 - WEIGHT_FRAC_BITS_DEF);
    endfunction

    function void smooth_map();
      logic [63:0] base;
      logic [63:0] delta[NUM_ANGLES];
      logic [63:0] acc;
      bit          found;
      int          ctr[2];
      int          cdist;
      base  = '0;
      found = 0;
      for (int a = 0; a < NUM_ANGLES; a++)
        if (present[a] && (!found || counts[a] < base)) begin
          base  = counts[a];
          found = 1;
        end
      for (int a = 0; a < NUM_ANGLES; a++) delta[a] = present[a] ? counts[a] - base : '0;
      map_total = '0;
      for (int b = 0; b < NUM_BINS; b++) begin
        acc = '0;
        for (int a = 0; a < NUM_ANGLES; a++) begin
          if (delta[a] == 0) continue;
          ctr[0] = a + 1;
          ctr[1] = (a + 1 + HALF_TURN) % NUM_BINS;
          for (int k = 0; k < 2; k++) begin
            cdist = (b > ctr[k]) ? b - ctr[k] : ctr[k] - b;
            if (cdist > HALF_TURN) cdist = NUM_BINS - cdist;
            if (cdist <= REACH) begin
              acc = acc + delta[a] * kernel[cdist];
              if (acc > ACC_SAT) acc = ACC_SAT;
            end
          end
        end
        bin_acc[b] = acc;
        map_total  = map_total + acc;
        if (map_total > TOTAL_SAT) map_total = TOTAL_SAT;
      end
    endfunction

    function void note_request(in_item_t it);
      out_item_t    r;
      logic [127:0] share;
      r = '0;
      case (cmd_t'(it.command))
        CMD_LOAD: begin
          if (it.angle >= 1 && it.angle <= NUM_ANGLES && it.count != 0) begin
            counts[it.angle-1]  = it.count;
            present[it.angle-1] = 1;
          end
        end
        CMD_CLEAR: begin
          for (int a = 0; a < NUM_ANGLES; a++) present[a] = 0;
        end
        CMD_COMPUTE: begin
          smooth_map();
          r.no_data = (map_total == 0);
          pending.push_back(r);
        end
        default: begin
          r.result_kind = 1'b1;
          r.bin_index   = it.bin;
          if (map_total == 0) begin
            r.no_data = 1'b1;
          end else if (it.bin < NUM_BINS) begin
            share = ({64'd0, bin_acc[it.bin]} << DENS_FRAC) / {64'd0, map_total};
            if (share > (128'd1 << DENS_FRAC)) share = 128'd1 << DENS_FRAC;
            r.density = share[DENS_W-1:0];
          end
          pending.push_back(r);
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("unexpected result item: kind %0d bin %0d", got.result_kind, got.bin_index);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, actual %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.bin_index !== want.bin_index) begin
        $error("bin_index: expected %0d, actual %0d", want.bin_index, got.bin_index);
        errors++;
      end
      if (got.density !== want.density) begin
        $error("density: expected %0d, actual %0d", want.density, got.density);
        errors++;
      end
      if (got.no_data !== want.no_data) begin
        $error("no_data: expected %0d, actual %0d", want.no_data, got.no_data);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  ahgs_in_if  req_if ();
  ahgs_out_if rsp_if ();

  angular_histogram_gauss_smooth u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  smooth_scoreboard sb;
  bit quiet;      // the last part of the run: no idling on either side
  bit hold_req;   // asks the receiver for one long hold-off
  int idle_count;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // Results are taken at the rising edge where valid and ready are both high.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
  end

  // The watchdog counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCH_MAX) begin
        $display("tb_angular_histogram_gauss_smooth: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random bursts of ready high and low. One long hold-off is
  // made on request while the sender keeps offering reads, so the output
  // register fills and the block stops taking items.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 0;
      end else if (quiet) begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 15);
        rsp_if.ready <= ($urandom_range(0, 2) != 0);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Offers one item and returns once it has been accepted. A random gap of
  // idle cycles may come first, outside the quiet tail.
  task automatic send_item(in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(it);
  endtask

  task automatic send_cmd(cmd_t c, int ang, int cnt, int b);
    in_item_t it;
    it.command = c;
    it.angle   = ang[ANG_W-1:0];
    it.count   = cnt[COUNT_IN_W-1:0];
    it.bin     = b[BIN_W-1:0];
    send_item(it);
  endtask

  // A random load: mostly valid angles with random counts, some noise that
  // the block must ignore (angle 0, angle above 180, zero count).
  task automatic random_load();
    int ang;
    int cnt;
    int pick;
    pick = $urandom_range(0, 19);
    ang  = (pick == 0) ? $urandom_range(181, 255) : (pick == 1) ? 0 : $urandom_range(1, 180);
    case ($urandom_range(0, 5))
      0:       cnt = 0;
      1:       cnt = $urandom_range(1, 255);
      2:       cnt = 24'hFFFFFF - $urandom_range(0, 255);
      default: cnt = $urandom & 24'hFFFFFF;
    endcase
    send_cmd(CMD_LOAD, ang, cnt, $urandom & 9'h1FF);
  endtask

  task automatic random_read();
    int b;
    b = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
    send_cmd(CMD_READ, $urandom & 8'hFF, $urandom & 24'hFFFFFF, b);
  endtask

  initial begin
    int pick;
    sb               = new();
    quiet            = 0;
    hold_req         = 0;
    idle_count       = 0;
    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.data      = '0;
    rsp_if.ready     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A read before any compute sees an empty map, and a
    // compute with nothing stored leaves the map empty too.
    send_cmd(CMD_READ, 0, 0, 5);
    send_cmd(CMD_COMPUTE, 0, 0, 0);
    // Loads that must be ignored: angle 0, angle above 180, zero count.
    send_cmd(CMD_LOAD, 0, 100, 0);
    send_cmd(CMD_LOAD, 181, 100, 0);
    send_cmd(CMD_LOAD, 255, 16777215, 511);
    send_cmd(CMD_LOAD, 10, 0, 0);
    // Extremes of angle and count, and an overwrite of a stored angle.
    send_cmd(CMD_LOAD, 1, 16777215, 0);
    send_cmd(CMD_LOAD, 180, 1, 0);
    send_cmd(CMD_LOAD, 90, 5000, 0);
    send_cmd(CMD_LOAD, 90, 7000, 0);
    send_cmd(CMD_COMPUTE, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 1);
    send_cmd(CMD_READ, 0, 0, 181);
    send_cmd(CMD_READ, 0, 0, 359);
    send_cmd(CMD_READ, 0, 0, 360);
    send_cmd(CMD_READ, 255, 16777215, 511);
    // A clear keeps the map; the following compute finds no stored angles.
    send_cmd(CMD_CLEAR, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 90);
    send_cmd(CMD_COMPUTE, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 3);

    // Random part. Computes are slow, so only a few are placed among
    // many loads and reads; the long receiver hold-off falls after the
    // first of them, when reads return data.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i >= N_RANDOM - QUIET_TAIL) quiet = 1;
      if (i == 600 || i == 1200 || i == 1850) begin
        send_cmd(CMD_COMPUTE, $urandom & 8'hFF, $urandom & 24'hFFFFFF, $urandom & 9'h1FF);
      end else begin
        if (i == 700) hold_req = 1;
        pick = $urandom_range(0, 99);
        if (i > 600 && i < 1850 && pick < 45) random_read();
        else if (pick < 3) send_cmd(CMD_CLEAR, $urandom & 8'hFF, $urandom & 24'hFFFFFF, 0);
        else if (pick < 8) random_read();
        else random_load();
      end
    end
    req_if.valid <= 1'b0;

    // Drain: every expected result must arrive, then a short settling time.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_angular_histogram_gauss_smooth: PASS");
    end else begin
      $display("tb_angular_histogram_gauss_smooth: FAIL");
    end
    $finish;
  end

endmodule
